@@ hw/rtl/tds_pkg.sv @@
`default_nettype none
package tds_pkg;

  // magnitude width taken from the input
  localparam int unsigned TICK_WIDTH = 64;

  // field widths
  localparam int unsigned DUR_W  = 64;
  localparam int unsigned RATE_W = 30;
  localparam int unsigned DAYS_W = 47;
  localparam int unsigned HRS_W  = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned REM_W  = 64;

  // derived divisor widths
  localparam int unsigned PMIN_W = RATE_W + 6;
  localparam int unsigned PHR_W  = RATE_W + 12;
  localparam int unsigned PDAY_W = RATE_W + 17;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_DAY  = 86400;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(1000000000);

  // one quotient bit per stage: days, then hours, minutes, seconds
  localparam int unsigned D_END = DAYS_W;
  localparam int unsigned H_END = D_END + HRS_W;
  localparam int unsigned M_END = H_END + MIN_W;
  localparam int unsigned N_STG = M_END + SEC_W;

  typedef struct packed {
    logic              neg;
    logic [REM_W-1:0]  rem;
    logic [DAYS_W-1:0] days;
    logic [HRS_W-1:0]  hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } stage_t;

endpackage
`default_nettype wire

@@ hw/rtl/tick_duration_splitter.sv @@
`default_nettype none
// tick_duration_splitter
// splits a signed duration in ticks into sign, days, hours, minutes,
// seconds and leftover ticks, using the tick rate held in one register.
// input channel: a transaction is taken at a clock edge with start_i high
// and busy_o low; busy_o is always low, so an item may enter every cycle.
// result channel: done_o is high for one cycle with all result fields
// valid; the receiver cannot stall it.
// configuration: cfg_we_i writes cfg_wdata_i into the rate register; the user must
// write it only while the block is idle, which the block itself does not enforce.
// a rate of 0 acts as 1. the per-minute, per-hour and per-day divisors are formed at the write.
// structure: one input register plus a 64 stage restoring divider, one
// quotient bit per stage (47 day bits, 5 hour, 6 minute, 6 second bits).
// throughput: one item per cycle.
// reset: empties the pipeline and loads the rate register with 1e9.
module tick_duration_splitter (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  output logic                      busy_o,
  input  wire [tds_pkg::DUR_W-1:0]  duration_ticks_i,
  input  wire                       cfg_we_i,
  input  wire [tds_pkg::RATE_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic                      is_negative_o,
  output logic [tds_pkg::DAYS_W-1:0] days_o,
  output logic [tds_pkg::HRS_W-1:0]  hours_o,
  output logic [tds_pkg::MIN_W-1:0]  minutes_o,
  output logic [tds_pkg::SEC_W-1:0]  seconds_o,
  output logic [tds_pkg::RATE_W-1:0] sub_second_ticks_o
);
  import tds_pkg::*;

  logic [RATE_W-1:0] rate_q, rate_d;
  logic [PMIN_W-1:0] pmin_q, pmin_d;
  logic [PHR_W-1:0]  phr_q, phr_d;
  logic [PDAY_W-1:0] pday_q, pday_d;

  // rate register and derived divisors
  always_comb begin
    rate_d = (cfg_wdata_i == '0) ? RATE_W'(1) : cfg_wdata_i;
    pmin_d = PMIN_W'(rate_d) * PMIN_W'(SECS_PER_MIN);
    phr_d  = PHR_W'(rate_d) * PHR_W'(SECS_PER_HOUR);
    pday_d = PDAY_W'(rate_d) * PDAY_W'(SECS_PER_DAY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      pmin_q <= PMIN_W'(RATE_RST) * PMIN_W'(SECS_PER_MIN);
      phr_q  <= PHR_W'(RATE_RST) * PHR_W'(SECS_PER_HOUR);
      pday_q <= PDAY_W'(RATE_RST) * PDAY_W'(SECS_PER_DAY);
    end else if (cfg_we_i) begin
      rate_q <= rate_d;
      pmin_q <= pmin_d;
      phr_q  <= phr_d;
      pday_q <= pday_d;
    end
  end

  assign busy_o = 1'b0;

  // input register: sign and magnitude
  logic [TICK_WIDTH-1:0] raw;
  logic [TICK_WIDTH-1:0] mag;
  logic                  in_vld_q;
  stage_t                in_q, in_d;

  always_comb begin
    raw  = duration_ticks_i[TICK_WIDTH-1:0];
    mag  = raw[TICK_WIDTH-1] ? (~raw + TICK_WIDTH'(1)) : raw;
    in_d = '0;
    in_d.neg = raw[TICK_WIDTH-1];
    in_d.rem = REM_W'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= in_d;
    end
  end

  // divider pipeline
  logic [N_STG-1:0] vld_q;
  stage_t           st_q [N_STG];

  for (genvar gs = 0; gs < N_STG; gs++) begin : g_stg
    stage_t     prv, nxt;
    logic       pvld;
    logic       hit;
    logic [REM_W-1:0] dv;

    if (gs == 0) begin : g_first
      assign prv  = in_q;
      assign pvld = in_vld_q;
    end else begin : g_next
      assign prv  = st_q[gs-1];
      assign pvld = vld_q[gs-1];
    end

    if (gs < D_END) begin : g_day
      localparam int unsigned K = D_END - 1 - gs;
      assign dv = REM_W'(pday_q);
      always_comb begin
        nxt = prv;
        hit = (prv.rem >> K) >= dv;
        if (hit) begin
          nxt.rem = prv.rem - (dv << K);
        end
        nxt.days[K] = hit;
      end
    end else if (gs < H_END) begin : g_hour
      localparam int unsigned K = H_END - 1 - gs;
      assign dv = REM_W'(phr_q);
      always_comb begin
        nxt = prv;
        hit = (prv.rem >> K) >= dv;
        if (hit) begin
          nxt.rem = prv.rem - (dv << K);
        end
        nxt.hours[K] = hit;
      end
    end else if (gs < M_END) begin : g_min
      localparam int unsigned K = M_END - 1 - gs;
      assign dv = REM_W'(pmin_q);
      always_comb begin
        nxt = prv;
        hit = (prv.rem >> K) >= dv;
        if (hit) begin
          nxt.rem = prv.rem - (dv << K);
        end
        nxt.minutes[K] = hit;
      end
    end else begin : g_sec
      localparam int unsigned K = N_STG - 1 - gs;
      assign dv = REM_W'(rate_q);
      always_comb begin
        nxt = prv;
        hit = (prv.rem >> K) >= dv;
        if (hit) begin
          nxt.rem = prv.rem - (dv << K);
        end
        nxt.seconds[K] = hit;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gs] <= 1'b0;
      end else begin
        vld_q[gs] <= pvld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pvld) begin
        st_q[gs] <= nxt;
      end
    end
  end

  // result transaction
  assign done_o             = vld_q[N_STG-1];
  assign is_negative_o      = st_q[N_STG-1].neg;
  assign days_o             = st_q[N_STG-1].days;
  assign hours_o            = st_q[N_STG-1].hours;
  assign minutes_o          = st_q[N_STG-1].minutes;
  assign seconds_o          = st_q[N_STG-1].seconds;
  assign sub_second_ticks_o = st_q[N_STG-1].rem[RATE_W-1:0];

endmodule
`default_nettype wire
